>>> hdl/go_back_n_send_window_unit_defines.svh
// ---------------------------------------------------------------------------
// go-back-n send window assertion macros
// immediate-free concurrent checks, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SEND_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SEND_WINDOW_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define GBN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("go-back-n send window check failed");
// next-cycle implication
`define GBN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("go-back-n send window check failed");
`else
`define GBN_ASSERT_SAME(label, ante, cons)
`define GBN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/gbn_pkg.sv
// ---------------------------------------------------------------------------
// gbn_pkg
// shared types, codes and field widths of the go-back-n send window unit
// ---------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W   = 16;
    localparam int FILE_W  = 24;
    localparam int WIN_W   = 7;
    localparam int TIMER_W = 16;
    localparam int LEN_W   = 10;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // event codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FIN  = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_FILE_SIZE     = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [SEQ_W-1:0] ack_number;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  sequence_res;
        logic [FILE_W-1:0] byte_offset;
        logic [LEN_W-1:0]  payload_length;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [FILE_W-1:0]  file_size;
        logic [WIN_W-1:0]   window_size;
        logic [TIMER_W-1:0] timeout_ticks;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic op_start;
        logic op_ack;
        logic op_tick;
        logic mul_base;
        logic mul_next;
        logic emit_data;
        logic emit_fin;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       active;
        logic       timeout;
        logic       fin_due;
        logic       cur_ok;
        logic       nxt_ok;
        logic       slot_free;
    } t_dp_status;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_MULB   = 6'b000100,
        S_ACKCHK = 6'b001000,
        S_MULN   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

>>> hdl/gbn_ctrl.sv
// ---------------------------------------------------------------------------
// gbn_ctrl
// sequencer: decodes one event, then steps the datapath through the send loop
// ---------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire gbn_pkg::t_dp_status i_status,
    output gbn_pkg::t_dp_cmd         o_cmd
);

    gbn_pkg::t_state r_state;
    gbn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            gbn_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = gbn_pkg::S_EVAL;
                end
            end
            gbn_pkg::S_EVAL: begin
                case (i_status.func)
                    gbn_pkg::FUNC_START: begin
                        o_cmd.op_start = 1'b1;
                        n_state        = gbn_pkg::S_MULN;
                    end
                    gbn_pkg::FUNC_ACK: begin
                        if (i_status.active) begin
                            o_cmd.op_ack = 1'b1;
                            n_state      = gbn_pkg::S_MULB;
                        end else begin
                            n_state = gbn_pkg::S_IDLE;
                        end
                    end
                    gbn_pkg::FUNC_TICK: begin
                        if (i_status.active) begin
                            o_cmd.op_tick = 1'b1;
                            n_state = i_status.timeout ? gbn_pkg::S_MULN : gbn_pkg::S_IDLE;
                        end else begin
                            n_state = gbn_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = gbn_pkg::S_IDLE;
                    end
                endcase
            end
            gbn_pkg::S_MULB: begin
                o_cmd.mul_base = 1'b1;
                n_state        = gbn_pkg::S_ACKCHK;
            end
            gbn_pkg::S_ACKCHK: begin
                if (i_status.fin_due) begin
                    if (i_status.slot_free) begin
                        o_cmd.emit_fin = 1'b1;
                        n_state        = gbn_pkg::S_IDLE;
                    end
                end else begin
                    n_state = gbn_pkg::S_MULN;
                end
            end
            gbn_pkg::S_MULN: begin
                o_cmd.mul_next = 1'b1;
                n_state        = gbn_pkg::S_EMIT;
            end
            gbn_pkg::S_EMIT: begin
                if (!i_status.cur_ok) begin
                    n_state = gbn_pkg::S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit_data = 1'b1;
                    if (!i_status.nxt_ok) begin
                        n_state = gbn_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = gbn_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == gbn_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> hdl/gbn_datapath.sv
// ---------------------------------------------------------------------------
// gbn_datapath
// window state, offset multiplier, send-loop compares and output register
// ---------------------------------------------------------------------------
`default_nettype none

module gbn_datapath #(
    parameter int PAYLOAD_BYTES = 512,
    parameter int MAX_WINDOW    = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gbn_pkg::t_cfg      i_cfg,
    input  wire gbn_pkg::t_in_word  i_in_data,
    input  wire gbn_pkg::t_dp_cmd   i_cmd,
    output gbn_pkg::t_dp_status     o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output gbn_pkg::t_out_word      o_out_data
);

    localparam int SEQ_W  = gbn_pkg::SEQ_W;
    localparam int FILE_W = gbn_pkg::FILE_W;
    localparam int WIN_W  = gbn_pkg::WIN_W;
    localparam int LEN_W  = gbn_pkg::LEN_W;
    localparam int OFF_W  = SEQ_W + $clog2(PAYLOAD_BYTES + 1);
    localparam int CMP_W  = (OFF_W + 1 > FILE_W) ? OFF_W + 1 : FILE_W;
    localparam int END_W  = SEQ_W + 1;
    localparam int N_W    = $clog2(MAX_WINDOW + 1);

    logic [1:0]                  r_func;
    logic [SEQ_W-1:0]            r_ack;
    logic [SEQ_W-1:0]            r_next_seq;
    logic [SEQ_W-1:0]            r_window_base;
    logic [gbn_pkg::TIMER_W-1:0] r_since_send;
    logic                        r_active;
    logic [CMP_W-1:0]            r_off;
    logic [N_W-1:0]              r_n;
    logic                        r_out_valid;
    gbn_pkg::t_out_word          r_out;

    logic [CMP_W-1:0]            w_fs;
    logic [CMP_W-1:0]            w_pay;
    logic [WIN_W-1:0]            w_win;
    logic [END_W-1:0]            w_end;
    logic [CMP_W-1:0]            w_off_step;
    logic [CMP_W-1:0]            w_off_nxt;
    logic [SEQ_W-1:0]            w_seq_nxt;
    logic [N_W-1:0]              w_n_nxt;
    logic [CMP_W-1:0]            w_len_full;
    logic [gbn_pkg::TIMER_W-1:0] w_since_inc;
    logic                        w_timeout;
    logic [SEQ_W-1:0]            w_mul_seq;
    logic [CMP_W-1:0]            w_prod;
    logic                        w_cur_ok;
    logic                        w_nxt_ok;
    logic                        w_slot_free;

    assign w_fs  = CMP_W'(i_cfg.file_size);
    assign w_pay = CMP_W'(PAYLOAD_BYTES);

    // effective window, clamped to the largest burst
    assign w_win = (i_cfg.window_size > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                            : i_cfg.window_size;
    assign w_end = {1'b0, r_window_base} + END_W'(w_win);

    // sequence numbers wrap at 16 bits, offset follows
    assign w_seq_nxt  = r_next_seq + SEQ_W'(1);
    assign w_off_step = r_off + w_pay;
    assign w_off_nxt  = (r_next_seq == '1) ? '0 : w_off_step;
    assign w_n_nxt    = r_n + N_W'(1);

    // seq below packet count is the same as seq * payload <= file size
    assign w_cur_ok = ({1'b0, r_next_seq} < w_end) && (r_off <= w_fs)
                      && (r_n < N_W'(MAX_WINDOW));
    assign w_nxt_ok = ({1'b0, w_seq_nxt} < w_end) && (w_off_nxt <= w_fs)
                      && (w_n_nxt < N_W'(MAX_WINDOW));

    assign w_len_full = (w_off_step < w_fs) ? w_pay : (w_fs - r_off);

    // saturating tick counter
    assign w_since_inc = (r_since_send == '1) ? r_since_send
                                              : r_since_send + gbn_pkg::TIMER_W'(1);
    assign w_timeout   = (w_since_inc >= i_cfg.timeout_ticks);

    assign w_mul_seq = i_cmd.mul_base ? r_window_base : r_next_seq;
    assign w_prod    = CMP_W'(w_mul_seq) * w_pay;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq    <= '0;
            r_window_base <= '0;
            r_since_send  <= '0;
            r_active      <= 1'b0;
            r_n           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.op_start) begin
                r_active      <= 1'b1;
                r_next_seq    <= '0;
                r_window_base <= '0;
                r_since_send  <= '0;
            end
            if (i_cmd.op_ack) begin
                r_window_base <= r_ack;
            end
            if (i_cmd.op_tick) begin
                r_since_send <= w_since_inc;
                if (w_timeout) begin
                    r_next_seq <= r_window_base;
                end
            end
            if (i_cmd.mul_next) begin
                r_n <= '0;
            end
            if (i_cmd.emit_data) begin
                r_next_seq   <= w_seq_nxt;
                r_n          <= w_n_nxt;
                r_since_send <= '0;
            end
            if (i_cmd.emit_fin) begin
                r_active <= 1'b0;
            end
            if (i_cmd.emit_data || i_cmd.emit_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_in_data.func;
            r_ack  <= i_in_data.ack_number;
        end
        if (i_cmd.mul_base || i_cmd.mul_next) begin
            r_off <= w_prod;
        end else if (i_cmd.emit_data) begin
            r_off <= w_off_nxt;
        end
        if (i_cmd.emit_data) begin
            r_out.kind           <= gbn_pkg::KIND_DATA;
            r_out.sequence_res   <= r_next_seq;
            r_out.byte_offset    <= r_off[FILE_W-1:0];
            r_out.payload_length <= w_len_full[LEN_W-1:0];
            r_out.last           <= !w_nxt_ok;
        end else if (i_cmd.emit_fin) begin
            r_out.kind           <= gbn_pkg::KIND_FIN;
            r_out.sequence_res   <= '0;
            r_out.byte_offset    <= '0;
            r_out.payload_length <= '0;
            r_out.last           <= 1'b1;
        end
    end

    assign o_status.func      = r_func;
    assign o_status.active    = r_active;
    assign o_status.timeout   = w_timeout;
    assign o_status.fin_due   = (r_off > w_fs);
    assign o_status.cur_ok    = w_cur_ok;
    assign o_status.nxt_ok    = w_nxt_ok;
    assign o_status.slot_free = w_slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/go_back_n_send_window_unit.sv
// ---------------------------------------------------------------------------
// go_back_n_send_window_unit
// go-back-n sender window control with an apb register port
// ---------------------------------------------------------------------------
// One input word is an event: start a transfer, a cumulative ack, or a one
// millisecond tick. Each event yields zero or more output words: data
// descriptors (sequence, byte offset, payload length) for every packet that
// fits the window, or a single FIN word once an ack covers the whole file;
// the final word of an event carries last. Events are handled one at a
// time. The send loop builds one descriptor a cycle in a shared adder and
// compare path, after the multiplier has turned a sequence number into a
// byte offset (the next sequence for a start or a timeout; for an ack the
// window base, then the next sequence unless a FIN is due); a full output
// register that is not taken holds the loop. Registers: file_size at 0x0,
// window_size at 0x4, timeout_ticks at 0x8; write them only while no event
// is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "go_back_n_send_window_unit_defines.svh"

module go_back_n_send_window_unit #(
    parameter int PAYLOAD_BYTES = 512,
    parameter int MAX_WINDOW    = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // event channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire gbn_pkg::t_in_word             i_in_data,

    // descriptor channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output gbn_pkg::t_out_word                 o_out_data,

    // apb register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gbn_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gbn_pkg::DATA_W-1:0]    pwdata,
    output logic [gbn_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    gbn_pkg::t_cfg       r_cfg;
    gbn_pkg::t_dp_cmd    w_cmd;
    gbn_pkg::t_dp_status w_status;
    logic                w_cfg_wr;
    logic [1:0]          w_reg_idx;

    // ------------------------------------------------------------------
    // register file: no wait states, write lands on the access cycle
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[gbn_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.file_size     <= '0;
            r_cfg.window_size   <= gbn_pkg::WIN_W'(8);
            r_cfg.timeout_ticks <= gbn_pkg::TIMER_W'(500);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                gbn_pkg::REG_FILE_SIZE: begin
                    r_cfg.file_size <= pwdata[gbn_pkg::FILE_W-1:0];
                end
                gbn_pkg::REG_WINDOW_SIZE: begin
                    r_cfg.window_size <= pwdata[gbn_pkg::WIN_W-1:0];
                end
                gbn_pkg::REG_TIMEOUT_TICKS: begin
                    r_cfg.timeout_ticks <= pwdata[gbn_pkg::TIMER_W-1:0];
                end
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // read mux, unmapped addresses read as zero
    always_comb begin
        case (w_reg_idx)
            gbn_pkg::REG_FILE_SIZE:     prdata = gbn_pkg::DATA_W'(r_cfg.file_size);
            gbn_pkg::REG_WINDOW_SIZE:   prdata = gbn_pkg::DATA_W'(r_cfg.window_size);
            gbn_pkg::REG_TIMEOUT_TICKS: prdata = gbn_pkg::DATA_W'(r_cfg.timeout_ticks);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: accepts an event only from its idle state, then walks
    // decode, offset multiply and the per-descriptor send loop
    // ------------------------------------------------------------------
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // ------------------------------------------------------------------
    // datapath: window base, next sequence, tick timer and the output
    // register, which lets a new event in while a word waits downstream
    // ------------------------------------------------------------------
    gbn_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .MAX_WINDOW    (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a new word never overwrites one that has not been taken
    `GBN_ASSERT_SAME(a_no_overwrite, w_cmd.emit_data || w_cmd.emit_fin, !o_out_valid || i_out_ready)
    // data and fin never loaded together
    `GBN_ASSERT_SAME(a_one_kind, w_cmd.emit_fin, !w_cmd.emit_data)
    // fin ends the transfer
    `GBN_ASSERT_NEXT(a_fin_idles, w_cmd.emit_fin, !w_status.active)
    // descriptors only leave while the loop condition holds
    `GBN_ASSERT_SAME(a_emit_in_window, w_cmd.emit_data, w_status.cur_ok && !o_in_ready)

endmodule

`default_nettype wire

>>> test/go_back_n_send_window_unit_tb.sv
// ---------------------------------------------------------------------------
// go_back_n_send_window_unit_tb
// drives start, ack and tick events into the go-back-n sender, predicts the
// data and FIN descriptors of each event in a scoreboard class and compares
// every output word in order, under random gaps on both channels
// ---------------------------------------------------------------------------
module go_back_n_send_window_unit_tb;

    localparam int PAYLOAD_BYTES = 512;
    localparam int MAX_WINDOW    = 64;
    localparam int RANDOM_EVENTS = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    localparam int SEQ_W   = gbn_pkg::SEQ_W;
    localparam int FILE_W  = gbn_pkg::FILE_W;
    localparam int WIN_W   = gbn_pkg::WIN_W;
    localparam int TIMER_W = gbn_pkg::TIMER_W;
    localparam int LEN_W   = gbn_pkg::LEN_W;
    localparam int ADDR_W  = gbn_pkg::ADDR_W;
    localparam int DATA_W  = gbn_pkg::DATA_W;

    // event code the block does not define, must be dropped
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // -----------------------------------------------------------------------
    // window tracker: mirrors the sender state and holds the words still due
    // -----------------------------------------------------------------------
    class send_window_tracker;
        int unsigned        file_size;
        int unsigned        window_size;
        int unsigned        timeout_ticks;
        int unsigned        next_seq;
        int unsigned        window_base;
        int unsigned        since_send;
        bit                 active;
        gbn_pkg::t_out_word due_words[$];
        int unsigned        bad_words;

        function new();
            file_size     = 0;
            window_size   = 8;
            timeout_ticks = 500;
            next_seq      = 0;
            window_base   = 0;
            since_send    = 0;
            active        = 1'b0;
            bad_words     = 0;
        endfunction

        function int unsigned packet_count();
            return file_size / PAYLOAD_BYTES + 1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                gbn_pkg::REG_FILE_SIZE:     file_size     = value[FILE_W-1:0];
                gbn_pkg::REG_WINDOW_SIZE:   window_size   = value[WIN_W-1:0];
                gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks = value[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        // queue a descriptor for every packet the window allows now
        function int unsigned fill_window();
            int unsigned        win;
            int unsigned        stop;
            int unsigned        n;
            longint unsigned    off;
            longint unsigned    len;
            gbn_pkg::t_out_word w;
            win  = (window_size > MAX_WINDOW) ? MAX_WINDOW : window_size;
            stop = window_base + win;
            if (stop > packet_count())
                stop = packet_count();
            n = 0;
            while (next_seq < stop && n < MAX_WINDOW) begin
                off = longint'(next_seq) * PAYLOAD_BYTES;
                if (off + PAYLOAD_BYTES < file_size)
                    len = PAYLOAD_BYTES;
                else if (off <= file_size)
                    len = file_size - off;
                else
                    len = 0;
                w.kind           = gbn_pkg::KIND_DATA;
                w.sequence_res   = next_seq[SEQ_W-1:0];
                w.byte_offset    = off[FILE_W-1:0];
                w.payload_length = len[LEN_W-1:0];
                w.last           = 1'b0;
                due_words.push_back(w);
                n++;
                next_seq = (next_seq + 1) & 32'hFFFF;
            end
            if (n > 0)
                since_send = 0;
            return n;
        endfunction

        // returns 1 when the event is not simply dropped by the block
        function bit take_event(gbn_pkg::t_in_word ev);
            int unsigned        n;
            bit                 acted;
            gbn_pkg::t_out_word tail;
            n     = 0;
            acted = 1'b0;
            case (ev.func)
                gbn_pkg::FUNC_START: begin
                    acted       = 1'b1;
                    active      = 1'b1;
                    next_seq    = 0;
                    window_base = 0;
                    since_send  = 0;
                    n = fill_window();
                end
                gbn_pkg::FUNC_ACK: begin
                    if (active) begin
                        acted       = 1'b1;
                        window_base = ev.ack_number;
                        if (window_base >= packet_count()) begin
                            tail = '0;
                            tail.kind = gbn_pkg::KIND_FIN;
                            due_words.push_back(tail);
                            active = 1'b0;
                            n = 1;
                        end else begin
                            n = fill_window();
                        end
                    end
                end
                gbn_pkg::FUNC_TICK: begin
                    if (active) begin
                        acted = 1'b1;
                        if (since_send < 32'hFFFF)
                            since_send++;
                        if (since_send >= timeout_ticks) begin
                            next_seq = window_base;
                            n = fill_window();
                        end
                    end
                end
                default: ;
            endcase
            // flag the final word of this event
            if (n > 0) begin
                tail = due_words.pop_back();
                tail.last = 1'b1;
                due_words.push_back(tail);
            end
            return acted;
        endfunction

        function void match_descriptor(gbn_pkg::t_out_word got);
            gbn_pkg::t_out_word want;
            if (due_words.size() == 0) begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT)
                    $display("%0t unexpected word: kind=%0d seq=%0d off=%0d len=%0d last=%0d",
                             $time, got.kind, got.sequence_res, got.byte_offset,
                             got.payload_length, got.last);
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.sequence_res !== want.sequence_res ||
                got.byte_offset !== want.byte_offset ||
                got.payload_length !== want.payload_length || got.last !== want.last) begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT) begin
                    $display("%0t word mismatch", $time);
                    $display("  want kind=%0d seq=%0d off=%0d len=%0d last=%0d",
                             want.kind, want.sequence_res, want.byte_offset,
                             want.payload_length, want.last);
                    $display("  got  kind=%0d seq=%0d off=%0d len=%0d last=%0d",
                             got.kind, got.sequence_res, got.byte_offset,
                             got.payload_length, got.last);
                end
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // signals and the block under test
    // -----------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    gbn_pkg::t_in_word  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    gbn_pkg::t_out_word o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    send_window_tracker tracker = new();

    bit          gaps_on;       // sender inserts idle cycles between words
    bit          stalls_on;     // receiver drops ready at random
    int unsigned next_gap;      // zero means valid is still high after the last word
    int unsigned live_events;   // events the block acts on
    int unsigned quiet_cycles;

    go_back_n_send_window_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // mostly back to back, sometimes a few cycles, now and then a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // one event word; valid stays up across back-to-back words
    task automatic send_event(input logic [1:0] func, input logic [SEQ_W-1:0] ack);
        gbn_pkg::t_in_word ev;
        ev.func       = func;
        ev.ack_number = ack;
        repeat (next_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        // accepted at this edge, so predict right away in this process
        if (tracker.take_event(ev))
            live_events++;
        next_gap = pick_gap();
        if (next_gap > 0)
            i_in_valid <= 1'b0;
    endtask

    // drop valid, wait for every due word, then let a no-output event finish
    task automatic settle();
        if (next_gap == 0) begin
            i_in_valid <= 1'b0;
            next_gap = 1;
        end
        while (tracker.due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup, then access until pready; junk above the field now and then
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        int unsigned       width;
        logic [DATA_W-1:0] word;
        case (idx)
            gbn_pkg::REG_FILE_SIZE:   width = FILE_W;
            gbn_pkg::REG_WINDOW_SIZE: width = WIN_W;
            default:                  width = TIMER_W;
        endcase
        word = value;
        if ($urandom_range(0, 3) == 0)
            word = word | ($urandom << width);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input int unsigned fs, input int unsigned win,
                             input int unsigned tmo);
        write_reg(gbn_pkg::REG_FILE_SIZE, fs);
        write_reg(gbn_pkg::REG_WINDOW_SIZE, win);
        write_reg(gbn_pkg::REG_TIMEOUT_TICKS, tmo);
    endtask

    // receiver: bursts of ready with random stalls, or always ready
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!stalls_on) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (pick_stall()) @(posedge i_clk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // output check and watchdog
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.match_descriptor(o_out_data);
    end

    // any handshake or register access counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[go_back_n_send_window_unit] ERROR");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned steps;
        int unsigned lo;
        int unsigned hi;
        int unsigned fs;
        int unsigned win;
        int unsigned tmo;
        logic [SEQ_W-1:0] ack;

        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        next_gap     = 1;
        live_events  = 0;
        quiet_cycles = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty file gives one zero-length packet
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);     // idle, dropped
        send_event(gbn_pkg::FUNC_ACK, 16'hFFFF);      // idle, dropped
        send_event(FUNC_UNUSED, 16'h5A5A);            // unused code, dropped
        send_event(gbn_pkg::FUNC_START, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);     // timer far from timeout
        send_event(gbn_pkg::FUNC_ACK, 16'd1);         // covers the file, FIN
        settle();

        // exact multiple of the payload: three packets, last one empty
        write_all(1024, 1, 1);
        send_event(gbn_pkg::FUNC_START, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);     // timeout resends the base
        send_event(gbn_pkg::FUNC_ACK, 16'd1);
        send_event(gbn_pkg::FUNC_ACK, 16'd0);         // ack below the base
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);
        send_event(gbn_pkg::FUNC_START, 16'h0000);    // restart while active
        send_event(gbn_pkg::FUNC_ACK, 16'd2);
        send_event(gbn_pkg::FUNC_ACK, 16'd3);
        settle();

        // largest file, window clamped to the maximum, timeout zero
        write_all(24'hFFFFFF, 127, 0);
        send_event(gbn_pkg::FUNC_START, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);
        send_event(gbn_pkg::FUNC_ACK, 16'd32767);     // ack far beyond next_seq
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);     // resend the final short packet
        send_event(gbn_pkg::FUNC_ACK, 16'd32768);
        settle();

        // zero window: nothing goes out and every tick that reaches the limit times out
        write_all(24'hFFFFFF, 0, 2);
        send_event(gbn_pkg::FUNC_START, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);
        send_event(gbn_pkg::FUNC_TICK, 16'h0000);
        send_event(gbn_pkg::FUNC_ACK, 16'hFFFF);
        settle();

        // random transfers: mostly in-window acks and ticks, some noise
        live_events = 0;
        while (live_events < RANDOM_EVENTS) begin
            settle();
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);

            r = $urandom_range(0, 99);
            if (r < 20)
                fs = PAYLOAD_BYTES * $urandom_range(0, 6);
            else if (r < 70)
                fs = $urandom_range(0, 7 * PAYLOAD_BYTES - 1);
            else if (r < 92)
                fs = $urandom_range(0, 40 * PAYLOAD_BYTES);
            else
                fs = $urandom_range(0, 24'hFFFFFF);

            r = $urandom_range(0, 99);
            if (r < 75)
                win = $urandom_range(1, 8);
            else if (r < 82)
                win = 0;
            else if (r < 94)
                win = $urandom_range(9, MAX_WINDOW);
            else
                win = $urandom_range(MAX_WINDOW + 1, 127);

            r = $urandom_range(0, 99);
            if (r < 70)
                tmo = $urandom_range(1, 4);
            else if (r < 80)
                tmo = 0;
            else if (r < 95)
                tmo = $urandom_range(5, 20);
            else
                tmo = $urandom_range(21, 65535);

            // occasionally leave a register at its previous value
            if ($urandom_range(0, 4) != 0)
                write_reg(gbn_pkg::REG_FILE_SIZE, fs);
            if ($urandom_range(0, 4) != 0)
                write_reg(gbn_pkg::REG_WINDOW_SIZE, win);
            if ($urandom_range(0, 4) != 0)
                write_reg(gbn_pkg::REG_TIMEOUT_TICKS, tmo);

            send_event(gbn_pkg::FUNC_START, SEQ_W'($urandom));
            steps = $urandom_range(5, 40);
            for (int k = 0; k < steps; k++) begin
                // once FIN is out, usually move to the next transfer
                if (!tracker.active && $urandom_range(0, 3) != 0)
                    break;
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    // cumulative ack inside the outstanding range, often all of it
                    lo = tracker.window_base;
                    hi = tracker.next_seq;
                    if (hi < lo) begin
                        lo = tracker.next_seq;
                        hi = tracker.window_base;
                    end
                    if (hi > 32'hFFFF)
                        hi = 32'hFFFF;
                    if (lo > hi)
                        lo = hi;
                    if ($urandom_range(0, 1))
                        ack = hi[SEQ_W-1:0];
                    else
                        ack = SEQ_W'($urandom_range(lo, hi));
                    send_event(gbn_pkg::FUNC_ACK, ack);
                end else if (r < 80) begin
                    send_event(gbn_pkg::FUNC_TICK, SEQ_W'($urandom));
                end else if (r < 86) begin
                    send_event(FUNC_UNUSED, SEQ_W'($urandom));
                end else if (r < 93) begin
                    send_event(gbn_pkg::FUNC_ACK, SEQ_W'($urandom));
                end else if (r < 96) begin
                    send_event(gbn_pkg::FUNC_START, SEQ_W'($urandom));
                end else begin
                    // hold off until the block has drained
                    settle();
                end
            end
        end

        settle();
        if (tracker.bad_words == 0 && tracker.due_words.size() == 0)
            $display("[go_back_n_send_window_unit] OK");
        else
            $display("[go_back_n_send_window_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_ctrl.sv
hdl/gbn_datapath.sv
hdl/go_back_n_send_window_unit.sv
test/go_back_n_send_window_unit_tb.sv
